// File: rtl/cwc_pkg.sv
// Shared types, word codes and sizes for the Catalan word clock phrase block.
// Used by the front, the queue, the back and the top level; no dependencies.
package cwc_pkg;

  // Sizes of one phrase and the default queue depth
  localparam int unsigned MaxWords     = 12;
  localparam int unsigned QueueDepthDf = 2;

  // Time constants of the quarter-based scheme
  localparam logic [5:0] HalfQuarter      = 6'd7;
  localparam logic [5:0] Quarter          = 6'd15;
  localparam logic [5:0] HalfAfterQuarter = 6'd22;
  localparam logic [4:0] EveningStart     = 5'd21;
  localparam logic [4:0] HourOnePm        = 5'd13;
  localparam logic [4:0] HourEleven       = 5'd11;
  localparam logic [4:0] HourMax          = 5'd23;
  localparam logic [5:0] MinuteMax        = 6'd59;

  // Display word codes
  localparam logic [5:0] W_EN          = 6'd0;
  localparam logic [5:0] W_PUNT        = 6'd1;
  localparam logic [5:0] W_I_PASSEN    = 6'd2;
  localparam logic [5:0] W_PASSEN_N    = 6'd3;
  localparam logic [5:0] W_MINUT_P     = 6'd4;
  localparam logic [5:0] W_MINUTS_P    = 6'd5;
  localparam logic [5:0] W_MIG_QUART   = 6'd6;
  localparam logic [5:0] W_QUART       = 6'd7;
  localparam logic [5:0] W_FALTA       = 6'd8;
  localparam logic [5:0] W_MINUT_F     = 6'd9;
  localparam logic [5:0] W_LACK_PL     = 6'd10;
  localparam logic [5:0] W_MINUTS_F    = 6'd11;
  localparam logic [5:0] W_LACK_N      = 6'd12;
  localparam logic [5:0] W_PER         = 6'd13;
  localparam logic [5:0] W_A           = 6'd14;
  localparam logic [5:0] W_UN          = 6'd15;
  localparam logic [5:0] W_I_MIG       = 6'd16;
  localparam logic [5:0] W_MIG         = 6'd17;
  localparam logic [5:0] W_DOS         = 6'd18;
  localparam logic [5:0] W_QUARTERS    = 6'd19;
  localparam logic [5:0] W_TRES        = 6'd20;
  localparam logic [5:0] W_HOUR        = 6'd21;
  localparam logic [5:0] W_DEL         = 6'd22;
  localparam logic [5:0] W_MATI        = 6'd23;
  localparam logic [5:0] W_NOON        = 6'd24;
  localparam logic [5:0] W_DE_DAY      = 6'd25;
  localparam logic [5:0] W_LA_DAY      = 6'd26;
  localparam logic [5:0] W_TARDA       = 6'd27;
  localparam logic [5:0] W_NIT         = 6'd28;
  localparam logic [5:0] W_DU          = 6'd29;
  localparam logic [5:0] W_DO          = 6'd30;
  localparam logic [5:0] W_DE_HOUR     = 6'd31;
  localparam logic [5:0] W_LA          = 6'd32;
  localparam logic [5:0] W_LES         = 6'd33;
  localparam logic [5:0] W_ES          = 6'd34;
  localparam logic [5:0] W_SON         = 6'd35;

  // One display word
  typedef struct packed {
    logic [5:0] code;
    logic [3:0] idx;
  } word_t;

  // One classified phrase: its words and how many are used
  typedef struct packed {
    word_t [MaxWords-1:0] words;
    logic  [3:0]          nwords;
  } phrase_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/cwc_front.sv
// Front end: clamps an hour and minute and classifies them into a word list.
// Depends on cwc_pkg for word codes and the phrase type.
module cwc_front (
  input  logic [4:0]       hour_i,
  input  logic [5:0]       minute_i,
  output cwc_pkg::phrase_t phrase_o
);

  logic [4:0] h;
  logic [4:0] h2;
  logic [5:0] m;
  logic [1:0] q;
  logic [5:0] q15;
  logic [3:0] r;
  logic       mid;

  // Append one word to the list unless it is full
  function automatic void put(inout cwc_pkg::phrase_t p, input logic [5:0] c,
                              input logic [3:0] i);
    if (p.nwords < 4'(cwc_pkg::MaxWords)) begin
      p.words[p.nwords[3:0]].code = c;
      p.words[p.nwords[3:0]].idx  = i;
      p.nwords = p.nwords + 4'd1;
    end
  endfunction

  function automatic logic is_one(input logic [4:0] hr);
    return (hr == 5'd1) || (hr == cwc_pkg::HourOnePm);
  endfunction

  function automatic void put_es_son(inout cwc_pkg::phrase_t p, input logic [4:0] hr,
                                     input logic [5:0] mn, input logic md);
    logic sing;
    if (is_one(hr)) begin
      sing = (mn <= cwc_pkg::HalfQuarter) || md;
    end else begin
      sing = (mn == cwc_pkg::HalfQuarter) || md;
    end
    put(p, sing ? cwc_pkg::W_ES : cwc_pkg::W_SON, 4'd0);
  endfunction

  function automatic void put_article(inout cwc_pkg::phrase_t p, input logic [4:0] hr);
    put(p, is_one(hr) ? cwc_pkg::W_LA : cwc_pkg::W_LES, 4'd0);
  endfunction

  function automatic void put_de(inout cwc_pkg::phrase_t p, input logic [4:0] hr);
    if (is_one(hr)) begin
      put(p, cwc_pkg::W_DU, 4'd0);
    end else if (hr == cwc_pkg::HourEleven || hr == cwc_pkg::HourMax) begin
      put(p, cwc_pkg::W_DO, 4'd0);
    end else begin
      put(p, cwc_pkg::W_DE_HOUR, 4'd0);
    end
  endfunction

  function automatic void put_quarters(inout cwc_pkg::phrase_t p, input logic [2:0] qq);
    if (qq == 3'd1) begin
      put(p, cwc_pkg::W_UN, 4'd0);
      put(p, cwc_pkg::W_QUART, 4'd0);
    end else if (qq == 3'd2) begin
      put(p, cwc_pkg::W_DOS, 4'd0);
      put(p, cwc_pkg::W_QUARTERS, 4'd0);
    end else begin
      put(p, cwc_pkg::W_TRES, 4'd0);
      put(p, cwc_pkg::W_QUARTERS, 4'd0);
    end
  endfunction

  function automatic void put_passen(inout cwc_pkg::phrase_t p, input logic [3:0] rr);
    put(p, cwc_pkg::W_I_PASSEN, 4'd0);
    put(p, cwc_pkg::W_PASSEN_N, rr - 4'd1);
    put(p, (rr == 4'd1) ? cwc_pkg::W_MINUT_P : cwc_pkg::W_MINUTS_P, 4'd0);
  endfunction

  // Clamp inputs and split the minute into quarters and remainder
  always_comb begin
    h = (hour_i > cwc_pkg::HourMax) ? cwc_pkg::HourMax : hour_i;
    m = (minute_i > cwc_pkg::MinuteMax) ? cwc_pkg::MinuteMax : minute_i;
    if (m >= 6'd45) begin
      q = 2'd3;
    end else if (m >= 6'd30) begin
      q = 2'd2;
    end else if (m >= cwc_pkg::Quarter) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    q15 = 6'(q) * cwc_pkg::Quarter;
    r   = 4'(m - q15);
    mid = (m >= cwc_pkg::Quarter) && (m <= cwc_pkg::HalfAfterQuarter);
  end

  // Build the word list
  always_comb begin
    phrase_o = '0;
    h2 = h;
    if (m < cwc_pkg::HalfQuarter) begin
      put_es_son(phrase_o, h, m, mid);
      put_article(phrase_o, h);
      if (m == 6'd0) begin
        put(phrase_o, cwc_pkg::W_EN, 4'd0);
        put(phrase_o, cwc_pkg::W_PUNT, 4'd0);
      end else begin
        put_passen(phrase_o, m[3:0]);
      end
    end else begin
      h2 = h + 5'd1;
      if (r >= 4'd8) begin
        if (r == 4'd14) begin
          put(phrase_o, cwc_pkg::W_FALTA, 4'd0);
          put(phrase_o, cwc_pkg::W_MINUT_F, 4'd0);
        end else begin
          put(phrase_o, cwc_pkg::W_LACK_PL, 4'd0);
          put(phrase_o, cwc_pkg::W_MINUTS_F, 4'd0);
        end
        put(phrase_o, cwc_pkg::W_LACK_N, r - 4'd8);
        put(phrase_o, cwc_pkg::W_PER, 4'd0);
        put(phrase_o, cwc_pkg::W_A, 4'd0);
        if (q == 2'd3) begin
          put_article(phrase_o, h2);
        end else begin
          put_quarters(phrase_o, 3'(q) + 3'd1);
          put_de(phrase_o, h2);
        end
      end else begin
        put_es_son(phrase_o, h2, m, mid);
        if (q == 2'd0) begin
          put(phrase_o, cwc_pkg::W_MIG_QUART, 4'd0);
          put(phrase_o, cwc_pkg::W_QUART, 4'd0);
          put_de(phrase_o, h2);
        end else begin
          put_quarters(phrase_o, 3'(q));
          if (r == 4'd7) begin
            put(phrase_o, cwc_pkg::W_I_MIG, 4'd0);
            put(phrase_o, cwc_pkg::W_MIG, 4'd0);
          end
          put_de(phrase_o, h2);
          if (r >= 4'd1 && r <= 4'd6) begin
            put_passen(phrase_o, r);
          end
        end
      end
    end

    // Hour word, named twelve at midnight and at the wrap past 23
    if (h2 == 5'd0) begin
      put(phrase_o, cwc_pkg::W_HOUR, 4'd11);
    end else if (h2 <= 5'd12) begin
      put(phrase_o, cwc_pkg::W_HOUR, 4'(h2 - 5'd1));
    end else begin
      put(phrase_o, cwc_pkg::W_HOUR, 4'(h2 - 5'd13));
    end

    // Part of day from the given hour
    if (h >= 5'd6 && h < 5'd12) begin
      put(phrase_o, cwc_pkg::W_DEL, 4'd0);
      put(phrase_o, cwc_pkg::W_MATI, 4'd0);
    end else if (h >= 5'd12 && h < 5'(cwc_pkg::Quarter)) begin
      put(phrase_o, cwc_pkg::W_DEL, 4'd0);
      put(phrase_o, cwc_pkg::W_NOON, 4'd0);
    end else if (h >= 5'(cwc_pkg::Quarter) && h < cwc_pkg::EveningStart) begin
      put(phrase_o, cwc_pkg::W_DE_DAY, 4'd0);
      put(phrase_o, cwc_pkg::W_LA_DAY, 4'd0);
      put(phrase_o, cwc_pkg::W_TARDA, 4'd0);
    end else begin
      put(phrase_o, cwc_pkg::W_DE_DAY, 4'd0);
      put(phrase_o, cwc_pkg::W_LA_DAY, 4'd0);
      put(phrase_o, cwc_pkg::W_NIT, 4'd0);
    end
  end

endmodule

// File: rtl/cwc_queue.sv
// Short phrase queue between the front end and the word sequencer.
// Depends on cwc_pkg for the phrase and status types.
module cwc_queue #(
  parameter int unsigned Depth = cwc_pkg::QueueDepthDf
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cwc_pkg::phrase_t     push_data_i,
  input  logic                 pop_i,
  output cwc_pkg::phrase_t     head_o,
  output cwc_pkg::q_status_t   status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cwc_pkg::phrase_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  // Advance pointers and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed phrase
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/cwc_back.sv
// Back end: steps through the head phrase and sends one word per cycle while not stalled.
// Depends on cwc_pkg for the phrase and status types.
module cwc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cwc_pkg::phrase_t   head_i,
  input  cwc_pkg::q_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         word_code_o,
  output logic [3:0]         word_index_o,
  output logic               last_word_o
);

  logic [3:0] pos_q, pos_d;
  logic       valid_q, valid_d;
  logic       load;
  logic       is_last;
  logic [5:0] code_q;
  logic [3:0] idx_q;
  logic       last_q;

  assign load    = !valid_q || !out_stall_i;
  assign is_last = (pos_q == head_i.nwords - 4'd1);
  assign pop_o   = load && !status_i.empty && is_last;

  // Advance the word position and the output valid
  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = !status_i.empty;
      if (!status_i.empty) begin
        pos_d = is_last ? 4'd0 : pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  // Load the output word register; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (load && !status_i.empty) begin
      code_q <= head_i.words[pos_q].code;
      idx_q  <= head_i.words[pos_q].idx;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign word_code_o  = code_q;
  assign word_index_o = idx_q;
  assign last_word_o  = last_q;

endmodule

// File: rtl/catalan_word_clock_phrase.sv
// Top level of the Catalan word clock phrase block.
// Instantiates cwc_front, cwc_queue and cwc_back; uses cwc_pkg.
//
// Usage:
//   Input channel: hour_i and minute_i with in_valid_i; the block drives
//   in_stall_o. A time is taken at an edge where in_valid_i is high and
//   in_stall_o is low. Out-of-range values saturate to 23 and 59.
//   Output channel: one display word per item on word_code_o, word_index_o
//   and last_word_o with out_valid_o; the receiver drives out_stall_i.
//   last_word_o marks the final word of each phrase.
// Path: the edge that takes a time writes the phrase queue; the word
//   sequencer then loads its first word into the output register.
// Throughput: one word per cycle from the output register while out_stall_i
//   is low; a phrase has 7 to 12 words. The word sequencer reading the
//   queue head sets this rate.
// Stalls: while out_stall_i is high the current word holds; the queue keeps
//   taking times until its QueueDepth entries are full, then in_stall_o
//   rises. Reset empties the queue and drops out_valid_o.
module catalan_word_clock_phrase #(
  parameter int unsigned QueueDepth = cwc_pkg::QueueDepthDf
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] hour_i,
  input  logic [5:0] minute_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] word_code_o,
  output logic [3:0] word_index_o,
  output logic       last_word_o
);

  cwc_pkg::phrase_t   phrase;
  cwc_pkg::phrase_t   head;
  cwc_pkg::q_status_t status;
  logic               push;
  logic               pop;

  // Accept a time whenever the queue has room
  assign in_stall_o = status.full;
  assign push       = in_valid_i && !status.full;

  cwc_front u_front (
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .phrase_o (phrase)
  );

  cwc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (phrase),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (status)
  );

  cwc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .status_i     (status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_code_o  (word_code_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

endmodule

// File: tb/tb_catalan_word_clock_phrase.sv
// Self-checking testbench for catalan_word_clock_phrase: random and directed times in,
// spelled Catalan word phrases checked word by word against an in-bench predictor.
// Depends on rtl/cwc_pkg.sv and rtl/catalan_word_clock_phrase.sv.
`timescale 1ns / 1ps

module tb_catalan_word_clock_phrase;

  localparam int unsigned RandomTimes = 410;
  localparam int unsigned PhaseLen    = 150;
  localparam int unsigned HoldAt      = 40;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PauseAt     = 200;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct {
    logic [4:0] hour;
    logic [5:0] minute;
  } clock_time_t;

  typedef struct {
    logic [5:0] code;
    logic [3:0] idx;
    logic       last;
  } lit_word_t;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [4:0] hour_i       = '0;
  logic [5:0] minute_i     = '0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [5:0] word_code_o;
  logic [3:0] word_index_o;
  logic       last_word_o;

  clock_time_t     times_q[$];
  cwc_pkg::word_t  phrase_q[$];
  lit_word_t       words_due_q[$];
  int unsigned words_due    = 0;
  int unsigned times_sent   = 0;
  int unsigned times_taken  = 0;
  int unsigned words_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          pause_wait   = 1'b0;
  bit          pause_done   = 1'b0;

  catalan_word_clock_phrase u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hour_i      (hour_i),
    .minute_i    (minute_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_code_o (word_code_o),
    .word_index_o(word_index_o),
    .last_word_o (last_word_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Idle rates per phase: receiver-heavy stalls first, then sender, then none
  function automatic int unsigned send_gap_pct(int unsigned n);
    if (n < PhaseLen) return 27;
    if (n < 2 * PhaseLen) return 74;
    return 0;
  endfunction

  function automatic int unsigned recv_gap_pct(int unsigned n);
    if (n < PhaseLen) return 74;
    if (n < 2 * PhaseLen) return 27;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Phrase predictor
  // ---------------------------------------------------------------------------
  function automatic void add_word(logic [5:0] code, logic [3:0] idx = 4'd0);
    cwc_pkg::word_t w;
    w.code = code;
    w.idx  = idx;
    if (phrase_q.size() < cwc_pkg::MaxWords) phrase_q.push_back(w);
  endfunction

  // "es" at the singular hour up to half a quarter, at half a quarter and in the mid-quarter span, "son" otherwise
  function automatic void add_verb(int unsigned hr, int unsigned mn);
    bit mid;
    mid = (mn >= cwc_pkg::Quarter && mn <= cwc_pkg::HalfAfterQuarter);
    if (hr == 1 || hr == cwc_pkg::HourOnePm)
      add_word((mn <= cwc_pkg::HalfQuarter || mid) ? cwc_pkg::W_ES : cwc_pkg::W_SON);
    else
      add_word((mn == cwc_pkg::HalfQuarter || mid) ? cwc_pkg::W_ES : cwc_pkg::W_SON);
  endfunction

  function automatic void add_article(int unsigned hr);
    add_word((hr == 1 || hr == cwc_pkg::HourOnePm) ? cwc_pkg::W_LA : cwc_pkg::W_LES);
  endfunction

  // Elide "de" before one and eleven
  function automatic void add_de(int unsigned hr);
    if (hr == 1 || hr == cwc_pkg::HourOnePm) add_word(cwc_pkg::W_DU);
    else if (hr == cwc_pkg::HourEleven || hr == cwc_pkg::HourMax) add_word(cwc_pkg::W_DO);
    else add_word(cwc_pkg::W_DE_HOUR);
  endfunction

  function automatic void add_quarters(int unsigned q);
    if (q == 1) begin
      add_word(cwc_pkg::W_UN);
      add_word(cwc_pkg::W_QUART);
    end else if (q == 2) begin
      add_word(cwc_pkg::W_DOS);
      add_word(cwc_pkg::W_QUARTERS);
    end else begin
      add_word(cwc_pkg::W_TRES);
      add_word(cwc_pkg::W_QUARTERS);
    end
  endfunction

  function automatic void add_passen(int unsigned r);
    add_word(cwc_pkg::W_I_PASSEN);
    add_word(cwc_pkg::W_PASSEN_N, 4'(r - 1));
    add_word((r == 1) ? cwc_pkg::W_MINUT_P : cwc_pkg::W_MINUTS_P);
  endfunction

  // Spell one time and queue its words as expected results
  function automatic void spell_time(logic [4:0] hour, logic [5:0] minute);
    int unsigned h, m, nh, q, r;
    lit_word_t   e;
    h  = (hour > cwc_pkg::HourMax) ? cwc_pkg::HourMax : hour;
    m  = (minute > cwc_pkg::MinuteMax) ? cwc_pkg::MinuteMax : minute;
    nh = h;
    phrase_q.delete();
    if (m < cwc_pkg::HalfQuarter) begin
      add_verb(h, m);
      add_article(h);
      if (m == 0) begin
        add_word(cwc_pkg::W_EN);
        add_word(cwc_pkg::W_PUNT);
      end else begin
        add_passen(m);
      end
    end else begin
      // from half a quarter on, count toward the next hour
      nh = h + 1;
      q  = m / cwc_pkg::Quarter;
      r  = m % cwc_pkg::Quarter;
      if (r > cwc_pkg::HalfQuarter) begin
        if (r == cwc_pkg::Quarter - 1) begin
          add_word(cwc_pkg::W_FALTA);
          add_word(cwc_pkg::W_MINUT_F);
        end else begin
          add_word(cwc_pkg::W_LACK_PL);
          add_word(cwc_pkg::W_MINUTS_F);
        end
        add_word(cwc_pkg::W_LACK_N, 4'(r - cwc_pkg::HalfQuarter - 1));
        add_word(cwc_pkg::W_PER);
        add_word(cwc_pkg::W_A);
        if (q == 3) begin
          add_article(nh);
        end else begin
          add_quarters(q + 1);
          add_de(nh);
        end
      end else begin
        add_verb(nh, m);
        if (q == 0) begin
          add_word(cwc_pkg::W_MIG_QUART);
          add_word(cwc_pkg::W_QUART);
          add_de(nh);
        end else begin
          add_quarters(q);
          if (r == cwc_pkg::HalfQuarter) begin
            add_word(cwc_pkg::W_I_MIG);
            add_word(cwc_pkg::W_MIG);
          end
          add_de(nh);
          if (r >= 1 && r < cwc_pkg::HalfQuarter) add_passen(r);
        end
      end
    end
    // hour word, twelve for midnight and for the hour after 23
    if (nh == 0) add_word(cwc_pkg::W_HOUR, 4'(cwc_pkg::HourEleven));
    else if (nh < cwc_pkg::HourOnePm) add_word(cwc_pkg::W_HOUR, 4'(nh - 1));
    else add_word(cwc_pkg::W_HOUR, 4'(nh - cwc_pkg::HourOnePm));
    // part of day follows the given hour
    if (h >= 6 && h < 12) begin
      add_word(cwc_pkg::W_DEL);
      add_word(cwc_pkg::W_MATI);
    end else if (h >= 12 && h < cwc_pkg::Quarter) begin
      add_word(cwc_pkg::W_DEL);
      add_word(cwc_pkg::W_NOON);
    end else begin
      add_word(cwc_pkg::W_DE_DAY);
      add_word(cwc_pkg::W_LA_DAY);
      add_word((h >= cwc_pkg::Quarter && h < cwc_pkg::EveningStart) ?
               cwc_pkg::W_TARDA : cwc_pkg::W_NIT);
    end
    foreach (phrase_q[k]) begin
      e.code = phrase_q[k].code;
      e.idx  = phrase_q[k].idx;
      e.last = (k == phrase_q.size() - 1);
      words_due_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_times
    bit held;
    bit offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      held = in_valid_i && in_stall_o;
      // retire the accepted request
      if (in_valid_i && !in_stall_o) begin
        void'(times_q.pop_front());
        times_sent++;
      end
      if (!held) begin
        offer = (times_q.size() != 0) && ($urandom_range(99) >= send_gap_pct(times_sent));
        // pause once until every expected word is out
        if (times_sent == PauseAt && !pause_done) begin
          offer = 1'b0;
          if (pause_wait && words_due == 0) pause_done = 1'b1;
          pause_wait = 1'b1;
        end
        in_valid_i <= offer;
        if (offer) begin
          hour_i   <= times_q[0].hour;
          minute_i <= times_q[0].minute;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word monitor, predictor hook and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_words
    lit_word_t want;
    bit        stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      // check the word taken at this edge
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (words_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] unexpected word: code=%0d idx=%0d last=%0d", cycles,
                     word_code_o, word_index_o, last_word_o);
        end else begin
          want = words_due_q.pop_front();
          if (word_code_o !== want.code || word_index_o !== want.idx ||
              last_word_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0d] word mismatch: expected code=%0d idx=%0d last=%0d, got %0d %0d %0d",
                       cycles, want.code, want.idx, want.last,
                       word_code_o, word_index_o, last_word_o);
          end
        end
      end
      // predict the request taken at this edge
      if (in_valid_i && !in_stall_o) begin
        spell_time(hour_i, minute_i);
        times_taken++;
      end
      // long hold-off once, random stalls otherwise
      if (hold_left != 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && times_taken >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        stall     = 1'b1;
      end else begin
        stall = $urandom_range(99) < recv_gap_pct(times_taken);
      end
      out_stall_i <= stall;
      words_due   <= words_due_q.size();
    end
  end

  // Timeout
  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("catalan_word_clock_phrase regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic add_time(int unsigned h, int unsigned m);
    clock_time_t t;
    t.hour   = 5'(h);
    t.minute = 6'(m);
    times_q.push_back(t);
  endtask

  initial begin : run
    int unsigned h, m;
    // on the hour, minutes past, falten, quarters, half quarters,
    // saturation and the roll past midnight
    add_time(0, 0);   add_time(1, 0);   add_time(13, 3);  add_time(14, 1);
    add_time(6, 6);   add_time(1, 7);   add_time(23, 7);  add_time(11, 8);
    add_time(11, 14); add_time(12, 15); add_time(15, 22); add_time(10, 23);
    add_time(20, 29); add_time(21, 37); add_time(5, 44);  add_time(6, 45);
    add_time(12, 52); add_time(22, 56); add_time(0, 59);  add_time(23, 59);
    add_time(23, 30); add_time(24, 60); add_time(31, 63);
    // random times, a few out of range
    repeat (RandomTimes) begin
      h = ($urandom_range(99) < 90) ? $urandom_range(23) : $urandom_range(31, 24);
      m = ($urandom_range(99) < 90) ? $urandom_range(59) : $urandom_range(63, 60);
      add_time(h, m);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests in, all words out, then a short tail
    do @(negedge clk_i); while (times_q.size() != 0 || words_due_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (words_due_q.size() != 0) mismatches++;

    $display("Spelled %0d times into %0d words across three stall mixes,", times_taken,
             words_seen);
    $display("with one long output hold-off and one input pause; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("catalan_word_clock_phrase regression: pass");
    end else begin
      $display("catalan_word_clock_phrase regression: fail");
    end
    $finish;
  end

endmodule
